// ===== sv/bpgm_pkg.sv =====
// Shared types and constants for the binary grey image (P5) stream parser.
// No dependencies; imported by bpgm_parse, binary_pgm_stream_parser, bpgm_checker and tb.
package bpgm_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC0  = 4'd0,
        PH_MAGIC1  = 4'd1,
        PH_SKIP_W  = 4'd2,
        PH_NUM_W   = 4'd3,
        PH_SKIP_H  = 4'd4,
        PH_NUM_H   = 4'd5,
        PH_SKIP_M  = 4'd6,
        PH_NUM_M   = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_HALT    = 4'd9
    } bpgm_phase_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_MAGIC   = 3'd1,
        ERR_MISSING = 3'd2,
        ERR_DIMS    = 3'd3,
        ERR_MAXVAL  = 3'd4,
        ERR_SHORT   = 3'd5,
        ERR_TRAIL   = 3'd6
    } bpgm_err_t;

    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_FIVE    = 8'h35;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam int unsigned MAXVAL_LIMIT = 255;

    // Result of one byte, before packing onto the master stream.
    typedef struct packed {
        logic        pixel_valid;
        logic [7:0]  pixel_value;
        logic        header_done;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  max_level;
        logic        done_res;
        bpgm_err_t   error_code;
    } bpgm_res_t;

endpackage

// ===== sv/bpgm_parse.sv =====
// Header parser and payload counter: state registers plus one byte of next-state logic.
// Depends on bpgm_pkg.
module bpgm_parse
    import bpgm_pkg::*;
#(
    parameter int DIM_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] byte_value,
    input  logic       last_byte,
    output bpgm_res_t  res
);

    localparam int AW = DIM_BITS + 4;
    localparam int PW = 2 * DIM_BITS;

    bpgm_phase_t         phase_reg, phase_next;
    bpgm_err_t           err_reg, err_next;
    logic                in_comment_reg, in_comment_next;
    logic [DIM_BITS-1:0] acc_reg, acc_next;
    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic [7:0]          maxval_reg, maxval_next;
    logic [PW-1:0]       remain_reg, remain_next;
    logic                over_reg, over_next;
    logic                hdr_reg, hdr_next;
    logic [PW-1:0]       prod_reg;

    logic                is_ws, is_digit, is_hash;
    logic [3:0]          dval;
    logic [AW-1:0]       acc_mul;
    logic                acc_ovf;
    logic                sk_comment, sk_digit, sk_bad;
    bpgm_err_t           close_code;

    // Checks made when maxval ends; ERR_NONE means the header is accepted.
    function automatic bpgm_err_t header_check(
        input logic [DIM_BITS-1:0] w,
        input logic [DIM_BITS-1:0] h,
        input logic [DIM_BITS-1:0] mv,
        input logic                has_sep
    );
        bpgm_err_t code;
        if (w == '0 || h == '0)
            code = ERR_DIMS;
        else if (mv == '0 || mv > DIM_BITS'(MAXVAL_LIMIT))
            code = ERR_MAXVAL;
        else if (!has_sep)
            code = ERR_MISSING;
        else
            code = ERR_NONE;
        return code;
    endfunction

    assign is_ws    = (byte_value == CH_SPACE) || (byte_value == CH_TAB) ||
                      (byte_value == CH_CR) || (byte_value == CH_LF);
    assign is_digit = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
    assign is_hash  = (byte_value == CH_HASH);
    assign dval     = 4'(byte_value - CH_ZERO);

    // acc * 10 + digit, with room to see the overflow
    assign acc_mul = (AW'(acc_reg) << 3) + (AW'(acc_reg) << 1) + AW'(dval);
    assign acc_ovf = |acc_mul[AW-1:DIM_BITS];

    // Skip-phase decode; in_comment is always clear once a number is running.
    assign sk_comment = in_comment_reg ? (byte_value != CH_LF) : is_hash;
    assign sk_digit   = !in_comment_reg && is_digit;
    assign sk_bad     = !in_comment_reg && !is_ws && !is_hash && !is_digit;

    assign close_code = header_check(width_reg, height_reg, acc_reg, is_ws);

    always_comb
    begin
        phase_next      = phase_reg;
        err_next        = err_reg;
        in_comment_next = in_comment_reg;
        acc_next        = acc_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        maxval_next     = maxval_reg;
        remain_next     = remain_reg;
        over_next       = over_reg;
        hdr_next        = hdr_reg;
        res.pixel_valid = 1'b0;

        unique case (phase_reg)
            PH_MAGIC0:
            begin
                if (byte_value == CH_P)
                    phase_next = PH_MAGIC1;
                else
                begin
                    err_next   = ERR_MAGIC;
                    phase_next = PH_HALT;
                end
            end
            PH_MAGIC1:
            begin
                if (byte_value == CH_FIVE)
                    phase_next = PH_SKIP_W;
                else
                begin
                    err_next   = ERR_MAGIC;
                    phase_next = PH_HALT;
                end
            end
            PH_SKIP_W, PH_SKIP_H, PH_SKIP_M:
            begin
                in_comment_next = sk_comment;
                if (sk_digit)
                begin
                    acc_next   = DIM_BITS'(dval);
                    phase_next = (phase_reg == PH_SKIP_W) ? PH_NUM_W :
                                 (phase_reg == PH_SKIP_H) ? PH_NUM_H : PH_NUM_M;
                end
                else if (sk_bad)
                begin
                    err_next   = ERR_MISSING;
                    phase_next = PH_HALT;
                end
            end
            PH_NUM_W, PH_NUM_H:
            begin
                if (is_digit)
                begin
                    acc_next = acc_mul[DIM_BITS-1:0];
                    if (acc_ovf)
                    begin
                        err_next   = ERR_MISSING;
                        phase_next = PH_HALT;
                    end
                end
                else
                begin
                    if (phase_reg == PH_NUM_W)
                        width_next = acc_reg;
                    else
                        height_next = acc_reg;
                    // the ending byte is handled as in the next skip phase
                    in_comment_next = sk_comment;
                    if (sk_digit)
                    begin
                        acc_next   = DIM_BITS'(dval);
                        phase_next = (phase_reg == PH_NUM_W) ? PH_NUM_H : PH_NUM_M;
                    end
                    else if (sk_bad)
                    begin
                        err_next   = ERR_MISSING;
                        phase_next = PH_HALT;
                    end
                    else
                        phase_next = (phase_reg == PH_NUM_W) ? PH_SKIP_H : PH_SKIP_M;
                end
            end
            PH_NUM_M:
            begin
                if (is_digit)
                begin
                    acc_next = acc_mul[DIM_BITS-1:0];
                    if (acc_ovf)
                    begin
                        err_next   = ERR_MISSING;
                        phase_next = PH_HALT;
                    end
                end
                else if (close_code != ERR_NONE)
                begin
                    err_next   = close_code;
                    phase_next = PH_HALT;
                end
                else
                begin
                    maxval_next = acc_reg[7:0];
                    remain_next = prod_reg;
                    over_next   = 1'b0;
                    hdr_next    = 1'b1;
                    phase_next  = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                res.pixel_valid = 1'b1;
                // remain counts down to zero; one byte past that sets over
                if (remain_reg == '0)
                    over_next = 1'b1;
                else
                    remain_next = remain_reg - PW'(1);
            end
            default:
            begin
            end
        endcase

        if (last_byte && err_next == ERR_NONE)
        begin
            if (phase_reg == PH_MAGIC0)
                err_next = ERR_MAGIC;
            else if (phase_next == PH_NUM_M)
                err_next = header_check(width_reg, height_reg, acc_next, 1'b0);
            else if (phase_next == PH_PAYLOAD)
            begin
                if (over_next)
                    err_next = ERR_TRAIL;
                else if (remain_next != '0)
                    err_next = ERR_SHORT;
            end
            else
                err_next = ERR_MISSING;
            if (err_next != ERR_NONE)
                phase_next = PH_HALT;
        end

        res.pixel_value  = res.pixel_valid ? byte_value : 8'h00;
        res.header_done  = hdr_next;
        res.image_width  = 32'(width_next);
        res.image_height = 32'(height_next);
        res.max_level    = maxval_next;
        res.done_res     = last_byte;
        res.error_code   = err_next;
    end

    // Product is ready well before maxval ends: at least two bytes follow the height.
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(width_reg) * PW'(height_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC0;
            err_reg        <= ERR_NONE;
            in_comment_reg <= 1'b0;
            acc_reg        <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            maxval_reg     <= '0;
            remain_reg     <= '0;
            over_reg       <= 1'b0;
            hdr_reg        <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg      <= PH_MAGIC0;
                err_reg        <= ERR_NONE;
                in_comment_reg <= 1'b0;
                acc_reg        <= '0;
                width_reg      <= '0;
                height_reg     <= '0;
                maxval_reg     <= '0;
                remain_reg     <= '0;
                over_reg       <= 1'b0;
                hdr_reg        <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                err_reg        <= err_next;
                in_comment_reg <= in_comment_next;
                acc_reg        <= acc_next;
                width_reg      <= width_next;
                height_reg     <= height_next;
                maxval_reg     <= maxval_next;
                remain_reg     <= remain_next;
                over_reg       <= over_next;
                hdr_reg        <= hdr_next;
            end
        end
    end

endmodule

// ===== sv/binary_pgm_stream_parser.sv =====
// Top level of the binary grey image (P5) stream parser: stream ports and output register.
// Depends on bpgm_pkg and bpgm_parse.
//
//  port group | dir | tdata (low bit up)                               | tuser       | tlast
//  s_axis     | in  | byte_value[7:0]                                  | -           | last_byte
//  m_axis     | out | pixel_value[7:0], header_done, image_width[31:0],| pixel_valid | done_res
//             |     | image_height[31:0], max_level[7:0], error_code,  |             |
//             |     | 4 zero pad bits                                  |             |
//
// One byte per cycle while the output register is free or m_axis_tready is high, one result per byte;
// the result is registered and appears in the cycle after the input transfer. The width times height product
// has its own register stage, hidden behind the maxval bytes. rst_n clears the parser to expect the first magic
// byte; the final byte does the same. The output register holds a result under back-pressure; s_axis_tready
// follows m_axis_tready while it is full.
module binary_pgm_stream_parser
    import bpgm_pkg::*;
#(
    parameter int DIM_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_value[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // pixel_value, header_done, image_width, image_height,
                                        // max_level, error_code, pad
    output logic        m_axis_tuser,   // pixel_valid
    output logic        m_axis_tlast
);

    logic        in_xfer;
    bpgm_res_t   res;
    logic        out_valid_reg;
    logic [87:0] out_data_reg;
    logic        out_user_reg;
    logic        out_last_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    bpgm_parse #(
        .DIM_BITS (DIM_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_xfer),
        .byte_value (s_axis_tdata),
        .last_byte  (s_axis_tlast),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_data_reg <= {4'b0000, res.error_code, res.max_level, res.image_height,
                             res.image_width, res.header_done, res.pixel_value};
            out_user_reg <= res.pixel_valid;
            out_last_reg <= res.done_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // a pixel never comes out ahead of an accepted header
    a_pix_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[8])
        else $error("pixel without header_done");

    // only the final byte can raise an error on a pixel
    a_pix_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser && !m_axis_tlast |-> m_axis_tdata[83:81] == ERR_NONE)
        else $error("pixel carries an error");

    // the final byte of a file is reported in the next cycle
    a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && s_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
        else $error("final byte result missing");

    // a clean file end never reports a header-less success
    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tdata[83:81] == ERR_NONE |-> m_axis_tdata[8])
        else $error("file ended without header and without error");

endmodule

// ===== bench/bpgm_checker.sv =====
`timescale 1ns / 1ps
// Checker for the P5 stream parser: predicts one result per byte and compares it with m_axis.
// Depends on bpgm_pkg; instantiated beside the block by tb.
module bpgm_checker
    import bpgm_pkg::*;
#(
    parameter int DIM_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          files_done,
    output int          pixel_count,
    output logic [6:0]  codes_seen
);

    localparam logic [63:0] DIM_LIMIT = (64'd1 << DIM_BITS) - 64'd1;

    // parser image
    bpgm_phase_t phase;
    logic        in_cmt;
    logic [63:0] acc;
    logic        dig_seen;
    logic [31:0] width_q;
    logic [31:0] height_q;
    logic [7:0]  maxval_q;
    logic [63:0] pix_expected;
    logic [63:0] pix_count;
    bpgm_err_t   err_q;

    bpgm_res_t   result_q[$];

    function automatic logic is_ws(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    task automatic clear_parser();
        phase        = PH_MAGIC0;
        in_cmt       = 1'b0;
        acc          = '0;
        dig_seen     = 1'b0;
        width_q      = '0;
        height_q     = '0;
        maxval_q     = '0;
        pix_expected = '0;
        pix_count    = '0;
        err_q        = ERR_NONE;
    endtask

    task automatic latch_err(bpgm_err_t code);
        err_q = code;
        phase = PH_HALT;
    endtask

    task automatic skip_byte(logic [7:0] b, bpgm_phase_t num_phase);
        if (in_cmt)
        begin
            if (b == CH_LF)
                in_cmt = 1'b0;
        end
        else if (!is_ws(b))
        begin
            if (b == CH_HASH)
                in_cmt = 1'b1;
            else if (is_digit(b))
            begin
                acc      = 64'(b - CH_ZERO);
                dig_seen = 1'b1;
                phase    = num_phase;
            end
            else
                latch_err(ERR_MISSING);
        end
    endtask

    // Checks at the end of maxval: dims, then range, then separator.
    task automatic close_header(logic has_sep);
        dig_seen = 1'b0;
        if (width_q == 0 || height_q == 0)
            latch_err(ERR_DIMS);
        else if (acc == 0 || acc > MAXVAL_LIMIT)
            latch_err(ERR_MAXVAL);
        else if (!has_sep)
            latch_err(ERR_MISSING);
        else
        begin
            maxval_q     = acc[7:0];
            pix_expected = 64'(width_q) * 64'(height_q);
            pix_count    = '0;
            phase        = PH_PAYLOAD;
        end
    endtask

    task automatic number_byte(logic [7:0] b);
        if (is_digit(b))
        begin
            acc = acc * 64'd10 + 64'(b - CH_ZERO);
            if (acc > DIM_LIMIT)
                latch_err(ERR_MISSING);
        end
        else
        begin
            dig_seen = 1'b0;
            if (phase == PH_NUM_W)
            begin
                width_q = acc[31:0];
                phase   = PH_SKIP_H;
                skip_byte(b, PH_NUM_H);
            end
            else if (phase == PH_NUM_H)
            begin
                height_q = acc[31:0];
                phase    = PH_SKIP_M;
                skip_byte(b, PH_NUM_M);
            end
            else
                close_header(is_ws(b));
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last, output bpgm_res_t r);
        logic pix;
        pix = 1'b0;
        case (phase)
            PH_MAGIC0:
            begin
                if (b == CH_P)
                    phase = PH_MAGIC1;
                else
                    latch_err(ERR_MAGIC);
                // a one-byte file is a bad magic, not a missing field
                if (last && err_q == ERR_NONE)
                    latch_err(ERR_MAGIC);
            end
            PH_MAGIC1:
            begin
                if (b == CH_FIVE)
                    phase = PH_SKIP_W;
                else
                    latch_err(ERR_MAGIC);
            end
            PH_SKIP_W: skip_byte(b, PH_NUM_W);
            PH_SKIP_H: skip_byte(b, PH_NUM_H);
            PH_SKIP_M: skip_byte(b, PH_NUM_M);
            PH_NUM_W, PH_NUM_H, PH_NUM_M: number_byte(b);
            PH_PAYLOAD:
            begin
                pix = 1'b1;
                if (pix_count <= pix_expected)
                    pix_count = pix_count + 64'd1;
            end
            default: ;
        endcase

        if (last && err_q == ERR_NONE)
        begin
            if (phase == PH_NUM_M)
                close_header(1'b0);
            else if (phase == PH_PAYLOAD)
            begin
                if (pix_count < pix_expected)
                    latch_err(ERR_SHORT);
                else if (pix_count > pix_expected)
                    latch_err(ERR_TRAIL);
            end
            else
                latch_err(ERR_MISSING);
        end

        r.pixel_valid  = pix;
        r.pixel_value  = pix ? b : 8'd0;
        r.header_done  = (phase == PH_PAYLOAD) || (pix_expected != 0);
        r.image_width  = width_q;
        r.image_height = height_q;
        r.max_level    = maxval_q;
        r.done_res     = last;
        r.error_code   = err_q;

        if (last)
            clear_parser();
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        bpgm_res_t want;
        bpgm_res_t got;
        if (!rst_n)
        begin
            clear_parser();
            result_q.delete();
            fail_count  = 0;
            files_done  = 0;
            pixel_count = 0;
            codes_seen  = '0;
            pending    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata, s_tlast, want);
                result_q.push_back(want);
                if (want.pixel_valid)
                    pixel_count++;
                if (want.done_res)
                begin
                    files_done++;
                    codes_seen[want.error_code] = 1'b1;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result transfer with no expected result outstanding");
                    fail_count++;
                end
                else
                begin
                    want             = result_q.pop_front();
                    got.pixel_valid  = m_tuser;
                    got.pixel_value  = m_tdata[7:0];
                    got.header_done  = m_tdata[8];
                    got.image_width  = m_tdata[40:9];
                    got.image_height = m_tdata[72:41];
                    got.max_level    = m_tdata[80:73];
                    got.error_code   = bpgm_err_t'(m_tdata[83:81]);
                    got.done_res     = m_tlast;
                    check_field("pixel_valid", 64'(want.pixel_valid), 64'(got.pixel_valid));
                    check_field("pixel_value", 64'(want.pixel_value), 64'(got.pixel_value));
                    check_field("header_done", 64'(want.header_done), 64'(got.header_done));
                    check_field("image_width", 64'(want.image_width), 64'(got.image_width));
                    check_field("image_height", 64'(want.image_height),
                                64'(got.image_height));
                    check_field("max_level", 64'(want.max_level), 64'(got.max_level));
                    check_field("done_res", 64'(want.done_res), 64'(got.done_res));
                    check_field("error_code", 64'(want.error_code), 64'(got.error_code));
                end
            end
            pending <= result_q.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top of the P5 stream parser bench: builds image files byte by byte and drives them in.
// Depends on bpgm_pkg, binary_pgm_stream_parser and bpgm_checker.
module tb
    import bpgm_pkg::*;
();

    localparam int ITEMS          = 1650;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int          fail_count;
    int          pending;
    int          files_done;
    int          pixel_count;
    logic [6:0]  codes_seen;

    int          tx_idle     = 33;
    int          rx_idle     = 79;
    int          sent        = 0;
    int          idle_cycles = 0;
    logic [7:0]  file_q[$];

    binary_pgm_stream_parser #(
        .DIM_BITS (32)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    bpgm_checker #(
        .DIM_BITS (32)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tlast     (s_axis_tlast),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .m_tlast     (m_axis_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .files_done  (files_done),
        .pixel_count (pixel_count),
        .codes_seen  (codes_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // any byte that ends a field with a missing-field error
    function automatic logic [7:0] junk_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SPACE || b == CH_TAB ||
               b == CH_CR || b == CH_LF || b == CH_HASH);
        return b;
    endfunction

    function automatic longint unsigned pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 4);
        else if (r < 95)
            return $urandom_range(5, 12);
        else if (r < 97)
            return 64'd4294967295;
        else
            return $urandom;
    endfunction

    function automatic longint unsigned pick_maxval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 255;
        else if (r < 20)
            return 1;
        else
            return $urandom_range(1, 255);
    endfunction

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++)
            file_q.push_back(s[i]);
    endtask

    task automatic put_num(longint unsigned v);
        if ($urandom_range(0, 9) == 0)
            put_str("0");
        put_str($sformatf("%0d", v));
    endtask

    // whitespace and comments between header fields
    task automatic put_sep(logic may_be_empty);
        int         n;
        logic [7:0] b;
        n = $urandom_range(may_be_empty ? 0 : 1, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 3) != 0)
                file_q.push_back(ws_char());
            else
            begin
                file_q.push_back(CH_HASH);
                repeat ($urandom_range(0, 5))
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_LF);
                    file_q.push_back(b);
                end
                file_q.push_back(CH_LF);
            end
        end
    endtask

    task automatic build_pgm(longint unsigned w, longint unsigned h, longint unsigned mv,
                             logic term_ok, int n_pix);
        file_q.delete();
        put_str("P5");
        put_sep(1'b1);
        put_num(w);
        put_sep(1'b0);
        put_num(h);
        put_sep(1'b0);
        put_num(mv);
        if (term_ok)
            file_q.push_back(ws_char());
        else
            file_q.push_back($urandom_range(0, 1) ? CH_HASH : junk_char());
        repeat (n_pix)
            file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_file();
        case (sent * 3 / ITEMS)
            0:       begin tx_idle = 33; rx_idle = 79; end
            1:       begin tx_idle = 79; rx_idle = 33; end
            default: begin tx_idle = 0;  rx_idle = 0;  end
        endcase
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == file_q.size() - 1);
        sent += file_q.size();
        file_q.delete();
    endtask

    initial
    begin
        int              kind;
        int              n;
        int              idx;
        longint unsigned w;
        longint unsigned h;
        longint unsigned mv;
        longint unsigned area;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one-byte file, bad first magic byte, comment right after the magic
        // with extreme pixels, width glued to the magic and zero width
        put_str("P");
        send_file();
        put_str("Q5");
        send_file();
        put_str("P5#\n1 2 255 ");
        file_q.push_back(8'h00);
        file_q.push_back(8'hFF);
        send_file();
        put_str("P50 1 1\n");
        send_file();

        while (sent < ITEMS)
        begin
            kind = $urandom_range(0, 99);
            w    = pick_dim();
            h    = pick_dim();
            mv   = pick_maxval();
            area = w * h;
            n    = (area <= 64) ? int'(area) : $urandom_range(0, 6);
            if (kind < 55)
                build_pgm(w, h, mv, 1'b1, n);
            else if (kind < 63)
                build_pgm(w, h, mv, 1'b1, (n > 0) ? $urandom_range(0, n - 1) : 0);
            else if (kind < 70)
                build_pgm(w, h, mv, 1'b1, n + $urandom_range(1, 3));
            else if (kind < 74)
            begin
                if ($urandom_range(0, 1))
                    w = 0;
                else
                    h = 0;
                build_pgm(w, h, mv, 1'b1, $urandom_range(0, 3));
            end
            else if (kind < 78)
            begin
                case ($urandom_range(0, 2))
                    0:       mv = 0;
                    1:       mv = $urandom_range(256, 100000);
                    default: mv = 64'd4294967295;
                endcase
                build_pgm(w, h, mv, 1'b1, $urandom_range(0, 3));
            end
            else if (kind < 82)
                build_pgm(w, h, mv, 1'b0, n);
            else if (kind < 86)
            begin
                // value one past the 32-bit range, or far past it
                area = 64'd4294967296 + $urandom_range(0, 100000);
                case ($urandom_range(0, 2))
                    0:       w  = area;
                    1:       h  = area;
                    default: mv = area;
                endcase
                build_pgm(w, h, mv, 1'b1, $urandom_range(0, 3));
            end
            else if (kind < 90)
            begin
                build_pgm(w, h, mv, 1'b1, n);
                idx = $urandom_range(2, file_q.size() - 1);
                file_q.insert(idx, junk_char());
            end
            else if (kind < 94)
            begin
                if ($urandom_range(0, 1))
                begin
                    // file ends on a maxval digit
                    build_pgm(w, h, mv, 1'b1, 0);
                    void'(file_q.pop_back());
                end
                else
                begin
                    build_pgm(w, h, mv, 1'b1, n);
                    idx = $urandom_range(1, file_q.size());
                    while (file_q.size() > idx)
                        void'(file_q.pop_back());
                end
            end
            else if (kind < 97)
            begin
                build_pgm(w, h, mv, 1'b1, n);
                file_q[$urandom_range(0, 1)] = 8'($urandom_range(0, 255));
            end
            else
            begin
                if ($urandom_range(0, 1))
                    put_str("P5");
                repeat ($urandom_range(1, 10))
                    file_q.push_back(8'($urandom_range(0, 255)));
            end
            send_file();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d files, %0d pixels; error codes seen (bit n = code n): %b",
                 sent, files_done, pixel_count, codes_seen);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
